[rtl/i2r_pkg.sv]
package i2r_pkg;

  localparam int unsigned VALUE_W    = 12;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned STEP_COUNT = 13;
  localparam int unsigned STEP_W     = 4;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

  localparam logic [CHAR_W-1:0] CH_NONE = 8'h00;
  localparam logic [CHAR_W-1:0] CH_I    = 8'h49;
  localparam logic [CHAR_W-1:0] CH_V    = 8'h56;
  localparam logic [CHAR_W-1:0] CH_X    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_L    = 8'h4C;
  localparam logic [CHAR_W-1:0] CH_C    = 8'h43;
  localparam logic [CHAR_W-1:0] CH_D    = 8'h44;
  localparam logic [CHAR_W-1:0] CH_M    = 8'h4D;

  typedef logic [STEP_W-1:0] step_idx_t;

  // Controller to datapath
  typedef struct packed {
    logic load;  // capture a new value
    logic emit;  // produce one letter into the output register
  } i2r_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;     // output register can take a letter this cycle
    logic last_letter;  // letter produced now closes the numeral
  } i2r_sts_t;

  function automatic logic [VALUE_W-1:0] step_value(input step_idx_t idx);
    logic [VALUE_W-1:0] v;
    case (idx)
      4'd0:    v = 12'd1000;
      4'd1:    v = 12'd900;
      4'd2:    v = 12'd500;
      4'd3:    v = 12'd400;
      4'd4:    v = 12'd100;
      4'd5:    v = 12'd90;
      4'd6:    v = 12'd50;
      4'd7:    v = 12'd40;
      4'd8:    v = 12'd10;
      4'd9:    v = 12'd9;
      4'd10:   v = 12'd5;
      4'd11:   v = 12'd4;
      4'd12:   v = 12'd1;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

  function automatic logic [CHAR_W-1:0] step_first(input step_idx_t idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      4'd0:    c = CH_M;
      4'd1:    c = CH_C;
      4'd2:    c = CH_D;
      4'd3:    c = CH_C;
      4'd4:    c = CH_C;
      4'd5:    c = CH_X;
      4'd6:    c = CH_L;
      4'd7:    c = CH_X;
      4'd8:    c = CH_X;
      4'd9:    c = CH_I;
      4'd10:   c = CH_V;
      4'd11:   c = CH_I;
      4'd12:   c = CH_I;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

  // Second letter of a subtractive pair; CH_NONE for single letters
  function automatic logic [CHAR_W-1:0] step_second(input step_idx_t idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      4'd1:    c = CH_M;
      4'd3:    c = CH_D;
      4'd5:    c = CH_C;
      4'd7:    c = CH_L;
      4'd9:    c = CH_X;
      4'd11:   c = CH_V;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

endpackage

[rtl/i2r_ctrl.sv]
module i2r_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output i2r_pkg::i2r_cmd_t cmd,
  input  i2r_pkg::i2r_sts_t sts
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);
  assign cmd.load = in_valid && (state_r == ST_IDLE);
  assign cmd.emit = (state_r == ST_RUN) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (cmd.emit && sts.last_letter) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_no_load_and_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.emit))
    else $error("load and emit in the same cycle");

  a_load_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_RUN))
    else $error("accepted value did not start conversion");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.last_letter) |=> (state_r == ST_IDLE))
    else $error("conversion ran past its final letter");

endmodule

[rtl/i2r_dp.sv]
module i2r_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  i2r_pkg::i2r_cmd_t                  cmd,
  output i2r_pkg::i2r_sts_t                  sts,
  input  logic [i2r_pkg::VALUE_W-1:0]        in_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [i2r_pkg::CHAR_W-1:0]         out_letter,
  output logic                               out_last,
  output logic                               out_invalid
);

  logic [i2r_pkg::VALUE_W-1:0] rem_r, rem_nxt;
  logic                        invalid_r, invalid_nxt;
  logic                        pend_r, pend_nxt;
  i2r_pkg::step_idx_t          pend_idx_r, pend_idx_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [i2r_pkg::CHAR_W-1:0]  out_letter_r, out_letter_nxt;
  logic                        out_last_r, out_last_nxt;
  logic                        out_invalid_r, out_invalid_nxt;

  i2r_pkg::step_idx_t          sel;
  logic [i2r_pkg::VALUE_W-1:0] sel_val;
  logic                        sel_pair;
  logic [i2r_pkg::CHAR_W-1:0]  letter;
  logic                        letter_last;

  // Largest step not above the remainder: independent compares, lowest index wins
  always_comb begin
    sel = i2r_pkg::step_idx_t'(i2r_pkg::STEP_COUNT - 1);
    for (int i = i2r_pkg::STEP_COUNT - 1; i >= 0; i--) begin
      if (rem_r >= i2r_pkg::step_value(i2r_pkg::step_idx_t'(i))) begin
        sel = i2r_pkg::step_idx_t'(i);
      end
    end
  end

  assign sel_val  = i2r_pkg::step_value(sel);
  assign sel_pair = (i2r_pkg::step_second(sel) != i2r_pkg::CH_NONE);

  always_comb begin
    if (invalid_r) begin
      letter      = i2r_pkg::CH_NONE;
      letter_last = 1'b1;
    end else if (pend_r) begin
      letter      = i2r_pkg::step_second(pend_idx_r);
      letter_last = (rem_r == '0);
    end else begin
      letter      = i2r_pkg::step_first(sel);
      letter_last = !sel_pair && (rem_r == sel_val);
    end
  end

  assign sts.out_free    = !out_valid_r || !out_stall;
  assign sts.last_letter = letter_last;

  always_comb begin
    rem_nxt         = rem_r;
    invalid_nxt     = invalid_r;
    pend_nxt        = pend_r;
    pend_idx_nxt    = pend_idx_r;
    out_valid_nxt   = out_valid_r;
    out_letter_nxt  = out_letter_r;
    out_last_nxt    = out_last_r;
    out_invalid_nxt = out_invalid_r;

    if (!out_stall) out_valid_nxt = 1'b0;

    if (cmd.load) begin
      rem_nxt     = in_value;
      invalid_nxt = (in_value == '0) || (in_value > i2r_pkg::VALUE_MAX);
      pend_nxt    = 1'b0;
    end

    if (cmd.emit) begin
      out_valid_nxt   = 1'b1;
      out_letter_nxt  = letter;
      out_last_nxt    = letter_last;
      out_invalid_nxt = invalid_r;
      if (pend_r) begin
        pend_nxt = 1'b0;
      end else if (!invalid_r) begin
        rem_nxt      = rem_r - sel_val;
        pend_nxt     = sel_pair;
        pend_idx_nxt = sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invalid_r   <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      invalid_r   <= invalid_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r         <= rem_nxt;
    pend_idx_r    <= pend_idx_nxt;
    out_letter_r  <= out_letter_nxt;
    out_last_r    <= out_last_nxt;
    out_invalid_r <= out_invalid_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_letter  = out_letter_r;
  assign out_last    = out_last_r;
  assign out_invalid = out_invalid_r;

  a_no_pend_on_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_r && invalid_r))
    else $error("second letter pending on an invalid value");

  a_emit_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && !invalid_r && !pend_r) |-> (rem_r != '0))
    else $error("letter emitted with nothing left to convert");

  a_emit_into_free_reg: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("letter overwrote a stalled result");

endmodule

[rtl/integer_to_roman_numeral.sv]
// Integer to Roman numeral converter. Each input beat carries a 12-bit
// unsigned value; the block answers with its Roman numeral as ASCII letters
// (I V X L C D M), one letter per output beat in reading order, with out_last
// high on the final letter. Conversion is greedy over 1000, 900, 500, 400,
// 100, 90, 50, 40, 10, 9, 5, 4 and 1, so subtractive pairs such as CM or IV
// come out as two consecutive beats. A value of 0 or above 3999 gives a
// single beat with out_letter zero and out_last and out_invalid both high.
// One value is converted at a time: once a value is accepted, each letter
// is loaded into the output register in turn, one letter per cycle while
// the output is not stalled. The next value is accepted as soon as the
// final letter has been loaded into the output register, even if that
// letter is still waiting to be taken. Nothing is kept between values.
module integer_to_roman_numeral (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [i2r_pkg::VALUE_W-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [i2r_pkg::CHAR_W-1:0]  out_letter,
  output logic                        out_last,
  output logic                        out_invalid
);

  i2r_pkg::i2r_cmd_t cmd;
  i2r_pkg::i2r_sts_t sts;

  // Controller: accept a value, then advance one letter per free output slot
  i2r_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Datapath: hold the remainder, pick the largest step, drive the output register
  i2r_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_letter  (out_letter),
    .out_last    (out_last),
    .out_invalid (out_invalid)
  );

endmodule
